// ===== rtl/core/fxd_pkg.sv =====
// fxd_pkg: shared types, widths and codes for the fixed-point divider core
// no dependencies; used by every module in rtl/core
`timescale 1ns / 1ps
`default_nettype none

package fxd_pkg;

    localparam int DATA_W    = 64;
    localparam int FRAC_BITS = 24;
    // dividend/quotient shift word: integer bits plus fraction bits
    localparam int DQ_W      = DATA_W + FRAC_BITS;
    // one restoring cell per quotient bit
    localparam int N_CELLS   = DQ_W;
    // magnitude bits that fit a positive signed result
    localparam int MAG_W     = DATA_W - 1;

    localparam logic [DATA_W-1:0] POS_SAT = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_SAT = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_code_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] numerator;
        logic signed [DATA_W-1:0] denominator;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] quotient_fixed;
        err_code_t                error_code;
    } out_item_t;

    // state carried along the chain of restoring cells
    typedef struct packed {
        logic              div_zero;
        logic              neg;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] div;
        logic [DQ_W-1:0]   dq;
    } cell_t;

    // state after the rounding decision
    typedef struct packed {
        logic             div_zero;
        logic             neg;
        logic             ovf;
        logic             rnd;
        logic [MAG_W-1:0] mag;
    } round_t;

endpackage

`default_nettype wire

// ===== rtl/core/fxd_div_cell.sv =====
// fxd_div_cell: one restoring shift-and-subtract step with its pipeline register
// depends on fxd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fxd_div_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire fxd_pkg::cell_t in_cell,
    output logic               out_valid,
    output fxd_pkg::cell_t     out_cell
);

    logic [fxd_pkg::DATA_W:0]   trial;
    logic [fxd_pkg::DATA_W+1:0] diff;
    logic                       ge;
    fxd_pkg::cell_t             cell_next;
    fxd_pkg::cell_t             cell_reg;
    logic                       valid_reg;

    // bring down the next dividend bit and try the subtract
    always_comb begin
        trial = {in_cell.rem, in_cell.dq[fxd_pkg::DQ_W-1]};
        diff  = {1'b0, trial} - {2'b00, in_cell.div};
        ge    = ~diff[fxd_pkg::DATA_W+1];
        cell_next     = in_cell;
        cell_next.rem = ge ? diff[fxd_pkg::DATA_W-1:0] : trial[fxd_pkg::DATA_W-1:0];
        cell_next.dq  = {in_cell.dq[fxd_pkg::DQ_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fxd_round_cell.sv =====
// fxd_round_cell: round half up decision on the magnitude and integer overflow check
// depends on fxd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fxd_round_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire fxd_pkg::cell_t in_cell,
    output logic               out_valid,
    output fxd_pkg::round_t    out_round
);

    fxd_pkg::round_t round_next;
    fxd_pkg::round_t round_reg;
    logic            valid_reg;

    always_comb begin
        round_next.div_zero = in_cell.div_zero;
        round_next.neg      = in_cell.neg;
        // any quotient bit at or above the sign position is overflow
        round_next.ovf      = |in_cell.dq[fxd_pkg::DQ_W-1:fxd_pkg::MAG_W];
        // twice the remainder against the divisor
        round_next.rnd      = ({in_cell.rem, 1'b0} >= {1'b0, in_cell.div});
        round_next.mag      = in_cell.dq[fxd_pkg::MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            round_reg <= round_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_round = round_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fxd_out_buf.sv =====
// fxd_out_buf: sign, saturation and error coding, output register with skid stage
// depends on fxd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fxd_out_buf (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire fxd_pkg::round_t in_round,
    output logic                adv,
    output logic                m_valid,
    input  wire logic           m_ready,
    output fxd_pkg::out_item_t  m_item
);

    fxd_pkg::out_item_t fmt_item;
    fxd_pkg::out_item_t out_reg;
    fxd_pkg::out_item_t out_next;
    fxd_pkg::out_item_t skid_reg;
    fxd_pkg::out_item_t skid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;

    // negate as ~mag + !rnd so rounding and sign share one adder
    function automatic fxd_pkg::out_item_t format_item(fxd_pkg::round_t r);
        fxd_pkg::out_item_t        o;
        logic [fxd_pkg::DATA_W-1:0] base;
        logic                       cin;
        base = r.neg ? ~{1'b0, r.mag} : {1'b0, r.mag};
        cin  = r.neg ? ~r.rnd : r.rnd;
        priority if (r.div_zero) begin
            o.quotient_fixed = '0;
            o.error_code     = fxd_pkg::ERR_DIV_ZERO;
        end else if (r.ovf) begin
            o.quotient_fixed = r.neg ? fxd_pkg::NEG_SAT : fxd_pkg::POS_SAT;
            o.error_code     = fxd_pkg::ERR_OVERFLOW;
        end else if (!r.neg && r.rnd && (&r.mag)) begin
            // rounding carried a positive magnitude up to the sign bit
            o.quotient_fixed = fxd_pkg::POS_SAT;
            o.error_code     = fxd_pkg::ERR_OVERFLOW;
        end else begin
            o.quotient_fixed = base + {{(fxd_pkg::DATA_W-1){1'b0}}, cin};
            o.error_code     = fxd_pkg::ERR_NONE;
        end
        return o;
    endfunction

    assign fmt_item = format_item(in_round);
    assign adv      = ~skid_valid_reg;

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !m_ready) begin
            if (in_valid && !skid_valid_reg) begin
                skid_next       = fmt_item;
                skid_valid_next = 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end else begin
            out_next       = fmt_item;
            out_valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    a_skid_catches: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && !skid_valid_reg && in_valid) |=> skid_valid_reg)
        else $error("item from the pipeline was not caught by the skid stage");

endmodule

`default_nettype wire

// ===== rtl/core/fraction_to_fixed_divider_core.sv =====
// an accepted item reaches m_valid via the preparation, cell, rounding and output registers
// throughput: one item per cycle; one restoring cell per quotient bit (FRAC_BITS + 64 cells)
// a stalled output parks one result in a skid stage, the pipeline holds only once that is full
// reset: aresetn synchronous, active low, clears every valid bit; datapath is not reset
// depends on fxd_pkg, fxd_div_cell, fxd_round_cell, fxd_out_buf
`timescale 1ns / 1ps
`default_nettype none

module fraction_to_fixed_divider_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire fxd_pkg::in_item_t s_item,
    output logic                m_valid,
    input  wire logic           m_ready,
    output fxd_pkg::out_item_t  m_item
);

    // pipeline advance, low only while the skid stage is occupied
    logic adv;

    // operand preparation stage: magnitudes, sign of result, zero divisor
    logic [fxd_pkg::DATA_W-1:0] num_u;
    logic [fxd_pkg::DATA_W-1:0] den_u;
    logic [fxd_pkg::DATA_W-1:0] num_mag;
    logic [fxd_pkg::DATA_W-1:0] den_mag;
    fxd_pkg::cell_t             prep_next;
    fxd_pkg::cell_t             prep_reg;
    logic                       prep_valid_reg;

    // chain of restoring cells; index 0 is the preparation register
    logic                       cell_valid [fxd_pkg::N_CELLS+1];
    fxd_pkg::cell_t             cell_data  [fxd_pkg::N_CELLS+1];

    logic                       rnd_valid;
    fxd_pkg::round_t            rnd_data;

    assign s_ready = adv;

    // the most negative value's magnitude is taken as an unsigned 2^63
    always_comb begin
        num_u   = s_item.numerator;
        den_u   = s_item.denominator;
        num_mag = num_u[fxd_pkg::DATA_W-1] ? ('0 - num_u) : num_u;
        den_mag = den_u[fxd_pkg::DATA_W-1] ? ('0 - den_u) : den_u;
        prep_next.div_zero = (den_u == '0);
        prep_next.neg      = num_u[fxd_pkg::DATA_W-1] ^ den_u[fxd_pkg::DATA_W-1];
        prep_next.rem      = '0;
        prep_next.div      = den_mag;
        // dividend pre-scaled by the fraction bits, consumed msb first
        prep_next.dq       = {num_mag, {fxd_pkg::FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (adv) begin
            prep_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prep_reg <= prep_next;
        end
    end

    assign cell_valid[0] = prep_valid_reg;
    assign cell_data[0]  = prep_reg;

    // each cell produces one quotient bit, integer part first
    for (genvar k = 0; k < fxd_pkg::N_CELLS; k++) begin : g_cell
        fxd_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (cell_valid[k]),
            .in_cell   (cell_data[k]),
            .out_valid (cell_valid[k+1]),
            .out_cell  (cell_data[k+1])
        );
    end

    // rounding decision from the final remainder
    fxd_round_cell u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (cell_valid[fxd_pkg::N_CELLS]),
        .in_cell   (cell_data[fxd_pkg::N_CELLS]),
        .out_valid (rnd_valid),
        .out_round (rnd_data)
    );

    // sign, saturation, output register and skid stage
    fxd_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rnd_valid),
        .in_round (rnd_data),
        .adv      (adv),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    a_stall_only_behind_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result waiting at the output");

    a_item_enters_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> prep_valid_reg)
        else $error("accepted item missing from the preparation stage");

    a_overflow_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.error_code == fxd_pkg::ERR_OVERFLOW)) |->
        ((m_item.quotient_fixed == fxd_pkg::POS_SAT) ||
         (m_item.quotient_fixed == fxd_pkg::NEG_SAT)))
        else $error("overflow result is not saturated");

endmodule

`default_nettype wire
